FILE: design/kcf_pkg.sv
// Shared types and constants for the Krauss car-following acceleration block.
package kcf_pkg;

  // Pipeline and queue sizing
  localparam int SQ_STAGES  = 31;   // one root bit per stage, 62-bit radicand
  localparam int DIV_STAGES = 26;   // one quotient bit per stage, 26-bit dividend
  localparam int Q_DEPTH    = 8;
  localparam int Q_AW       = $clog2(Q_DEPTH);
  localparam int Q_BUSY_LVL = 4;    // leaves room for words still in the front stages

  // Configuration register indexes
  localparam logic [2:0] CFG_DESIRED = 3'd0;
  localparam logic [2:0] CFG_LIMIT   = 3'd1;
  localparam logic [2:0] CFG_ACCEL   = 3'd2;
  localparam logic [2:0] CFG_DECEL   = 3'd3;
  localparam logic [2:0] CFG_MIN_GAP = 3'd4;
  localparam logic [2:0] CFG_EPS     = 3'd5;
  localparam logic [2:0] CFG_STEP    = 3'd6;

  // Reset values
  localparam logic [15:0] RST_DESIRED = 16'd8533;
  localparam logic [15:0] RST_LIMIT   = 16'd65535;
  localparam logic [11:0] RST_ACCEL   = 12'd512;
  localparam logic [11:0] RST_DECEL   = 12'd1152;
  localparam logic [15:0] RST_MIN_GAP = 16'd640;
  localparam logic [15:0] RST_EPS     = 16'd32768;
  localparam logic [15:0] RST_STEP    = 16'd1024;

  // Query kinds
  localparam logic [1:0] KIND_LEADER = 2'd0;
  localparam logic [1:0] KIND_STOP   = 2'd1;
  localparam logic [1:0] KIND_FREE   = 2'd2;

  // Output saturation
  localparam logic [25:0] ACC_POS_LIM = 26'd1048575;
  localparam logic [25:0] ACC_NEG_LIM = 26'd1048576;
  localparam logic [20:0] ACC_MAX     = 21'h0FFFFF;
  localparam logic [20:0] ACC_MIN     = 21'h100000;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // Live configuration, step time already forced nonzero
  typedef struct packed {
    logic [15:0] desired;
    logic [15:0] limit;
    logic [11:0] accel;
    logic [11:0] decel;
    logic [15:0] min_gap;
    logic [15:0] eps;
    logic [15:0] t;
  } cfg_t;

  // Word handed from front to back through the queue
  typedef struct packed {
    logic        lead;    // safe-speed term applies
    logic [61:0] rad;     // bT^2 + vl^2 + 2*b*gap*2^16
    logic [25:0] bt;
    logic [23:0] vup0;    // min(v+aT, min(desired, limit)), 2^-16 m/s
    logic [23:0] vdown;
    logic [23:0] v;
    logic [15:0] r;
  } qitem_t;

endpackage

FILE: design/kcf_front.sv
// Front end: takes queries, classifies them and forms the radicand and speed bounds.
module kcf_front import kcf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        accept,
  input  logic [1:0]  kind,
  input  logic [31:0] front_pos,
  input  logic [15:0] speed,
  input  logic [31:0] lead_pos,
  input  logic [15:0] lead_speed,
  input  logic [15:0] rnd,
  output logic        push,
  output qitem_t      item
);

  // Stage 1: gap, bT, aT, leader speed
  logic        s1_vld_r, s1_lead_r;
  logic [23:0] s1_vl_r, s1_v_r;
  logic [31:0] s1_g_r;
  logic [25:0] s1_bt_r, s1_at_r;
  logic [15:0] s1_r_r;

  logic [27:0]        bprod, aprod;
  logic signed [33:0] gap;
  logic               is_lead;

  always_comb begin
    bprod   = cfg.decel * cfg.t;
    aprod   = cfg.accel * cfg.t;
    gap     = $signed({2'b00, lead_pos}) - $signed({2'b00, front_pos})
              - $signed({18'd0, cfg.min_gap});
    is_lead = (kind == KIND_LEADER) || (kind == KIND_STOP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept;
    end
    s1_lead_r <= is_lead;
    s1_vl_r   <= (kind == KIND_LEADER) ? {lead_speed, 8'd0} : 24'd0;
    s1_v_r    <= {speed, 8'd0};
    s1_g_r    <= (gap > 34'sd0) ? gap[31:0] : 32'd0;
    s1_bt_r   <= bprod[27:2];
    s1_at_r   <= aprod[27:2];
    s1_r_r    <= rnd;
  end

  // Stage 2: squares, b*gap, upper and lower speed bounds
  logic        s2_vld_r, s2_lead_r;
  logic [51:0] s2_bt2_r;
  logic [47:0] s2_vl2_r;
  logic [43:0] s2_bg_r;
  logic [25:0] s2_bt_r;
  logic [23:0] s2_vup0_r, s2_vdown_r, s2_v_r;
  logic [15:0] s2_r_r;

  logic [26:0] vsum;
  logic [15:0] cap;
  logic [23:0] capv, vup0, vdown;

  always_comb begin
    vsum  = {3'd0, s1_v_r} + {1'b0, s1_at_r};
    cap   = (cfg.desired < cfg.limit) ? cfg.desired : cfg.limit;
    capv  = {cap, 8'd0};
    vup0  = (vsum < {3'd0, capv}) ? vsum[23:0] : capv;
    vdown = ({2'b00, s1_v_r} > s1_bt_r) ? (s1_v_r - s1_bt_r[23:0]) : 24'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_lead_r  <= s1_lead_r;
    s2_bt2_r   <= s1_bt_r * s1_bt_r;
    s2_vl2_r   <= s1_vl_r * s1_vl_r;
    s2_bg_r    <= cfg.decel * s1_g_r;
    s2_bt_r    <= s1_bt_r;
    s2_vup0_r  <= vup0;
    s2_vdown_r <= vdown;
    s2_v_r     <= s1_v_r;
    s2_r_r     <= s1_r_r;
  end

  // Stage 3: radicand sum
  logic   s3_vld_r;
  qitem_t s3_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    s3_item_r.lead  <= s2_lead_r;
    s3_item_r.rad   <= {10'd0, s2_bt2_r} + {14'd0, s2_vl2_r} + {1'b0, s2_bg_r, 17'd0};
    s3_item_r.bt    <= s2_bt_r;
    s3_item_r.vup0  <= s2_vup0_r;
    s3_item_r.vdown <= s2_vdown_r;
    s3_item_r.v     <= s2_v_r;
    s3_item_r.r     <= s2_r_r;
  end

  assign push = s3_vld_r;
  assign item = s3_item_r;

endmodule

FILE: design/kcf_queue.sv
// Short queue between front and back; the back drains one word per cycle.
module kcf_queue import kcf_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  qitem_t wr_item,
  output logic   rd_valid,
  output qitem_t rd_item,
  output logic   busy
);

  qitem_t         mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   cnt_r, cnt_nxt;
  logic            pop;

  assign pop      = (cnt_r != '0);
  assign rd_valid = pop;
  assign rd_item  = mem_r[rd_ptr_r];
  assign busy     = (cnt_r >= (Q_AW+1)'(Q_BUSY_LVL));

  always_comb begin
    cnt_nxt = cnt_r + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_item;
  end

endmodule

FILE: design/kcf_sqrt.sv
// Pipelined integer square root, one root bit per stage, word carried alongside.
module kcf_sqrt import kcf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  qitem_t      in_item,
  output logic        out_vld,
  output logic [30:0] out_root,
  output qitem_t      out_item
);

  logic [SQ_STAGES-1:0] vld_r;
  qitem_t               itm_r  [SQ_STAGES];
  logic [32:0]          rem_r  [SQ_STAGES];
  logic [30:0]          root_r [SQ_STAGES];

  qitem_t      itm_in  [SQ_STAGES];
  qitem_t      itm_nxt [SQ_STAGES];
  logic [32:0] rem_in  [SQ_STAGES];
  logic [32:0] rem_nxt [SQ_STAGES];
  logic [30:0] root_in [SQ_STAGES];
  logic [30:0] root_nxt[SQ_STAGES];
  logic [34:0] remx    [SQ_STAGES];
  logic [34:0] trial   [SQ_STAGES];

  // Per stage: bring down two radicand bits, try root*4+1
  always_comb begin
    for (int k = 0; k < SQ_STAGES; k++) begin
      if (k == 0) begin
        itm_in[k]  = in_item;
        rem_in[k]  = '0;
        root_in[k] = '0;
      end else begin
        itm_in[k]  = itm_r[k-1];
        rem_in[k]  = rem_r[k-1];
        root_in[k] = root_r[k-1];
      end
      remx[k]  = {rem_in[k], itm_in[k].rad[61:60]};
      trial[k] = {2'b00, root_in[k], 2'b01};
      if (remx[k] >= trial[k]) begin
        rem_nxt[k]  = 33'(remx[k] - trial[k]);
        root_nxt[k] = {root_in[k][29:0], 1'b1};
      end else begin
        rem_nxt[k]  = remx[k][32:0];
        root_nxt[k] = {root_in[k][29:0], 1'b0};
      end
      itm_nxt[k]     = itm_in[k];
      itm_nxt[k].rad = {itm_in[k].rad[59:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[SQ_STAGES-2:0], in_vld};
    end
    for (int k = 0; k < SQ_STAGES; k++) begin
      itm_r[k]  <= itm_nxt[k];
      rem_r[k]  <= rem_nxt[k];
      root_r[k] <= root_nxt[k];
    end
  end

  assign out_vld  = vld_r[SQ_STAGES-1];
  assign out_root = root_r[SQ_STAGES-1];
  assign out_item = itm_r[SQ_STAGES-1];

endmodule

FILE: design/kcf_back.sv
// Back end: safe-speed bound, imperfection and random blends, divide by T, saturate.
module kcf_back import kcf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_vld,
  input  logic [30:0] root,
  input  qitem_t      in_item,
  output logic        out_vld,
  output logic [20:0] acc
);

  // B1: vSafe and final upper speed
  logic        b1_vld_r;
  logic [23:0] b1_vup_r, b1_vdown_r, b1_v_r;
  logic [15:0] b1_r_r;
  logic [30:0] vsafe;
  logic [23:0] vup;

  always_comb begin
    vsafe = root - {5'd0, in_item.bt};
    vup   = (in_item.lead && (vsafe < {7'd0, in_item.vup0})) ? vsafe[23:0] : in_item.vup0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) b1_vld_r <= 1'b0;
    else        b1_vld_r <= in_vld;
    b1_vup_r   <= vup;
    b1_vdown_r <= in_item.vdown;
    b1_v_r     <= in_item.v;
    b1_r_r     <= in_item.r;
  end

  // B2: imperfection products
  logic        b2_vld_r;
  logic [40:0] b2_p1_r, b2_p2_r;
  logic [23:0] b2_vup_r, b2_v_r;
  logic [15:0] b2_r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b2_vld_r <= 1'b0;
    else        b2_vld_r <= b1_vld_r;
    b2_p1_r  <= (ONE_Q16 - {1'b0, cfg.eps}) * b1_vup_r;
    b2_p2_r  <= {1'b0, cfg.eps} * b1_vdown_r;
    b2_vup_r <= b1_vup_r;
    b2_v_r   <= b1_v_r;
    b2_r_r   <= b1_r_r;
  end

  // B3: lower speed
  logic        b3_vld_r;
  logic [23:0] b3_vlow_r, b3_vup_r, b3_v_r;
  logic [15:0] b3_r_r;
  logic [40:0] psum;

  assign psum = b2_p1_r + b2_p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b3_vld_r <= 1'b0;
    else        b3_vld_r <= b2_vld_r;
    b3_vlow_r <= psum[39:16];
    b3_vup_r  <= b2_vup_r;
    b3_v_r    <= b2_v_r;
    b3_r_r    <= b2_r_r;
  end

  // B4: random pick products
  logic        b4_vld_r;
  logic [40:0] b4_q1_r, b4_q2_r;
  logic [23:0] b4_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b4_vld_r <= 1'b0;
    else        b4_vld_r <= b3_vld_r;
    b4_q1_r <= (ONE_Q16 - {1'b0, b3_r_r}) * b3_vlow_r;
    b4_q2_r <= {1'b0, b3_r_r} * b3_vup_r;
    b4_v_r  <= b3_v_r;
  end

  // B5: speed change, sign and magnitude times four
  logic        b5_vld_r, b5_neg_r;
  logic [25:0] b5_num_r;
  logic [40:0] qsum;
  logic [24:0] diff, mag;

  always_comb begin
    qsum = b4_q1_r + b4_q2_r;
    diff = {1'b0, qsum[39:16]} - {1'b0, b4_v_r};
    mag  = diff[24] ? (25'd0 - diff) : diff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) b5_vld_r <= 1'b0;
    else        b5_vld_r <= b4_vld_r;
    b5_neg_r <= diff[24];
    b5_num_r <= {mag[23:0], 2'b00};
  end

  // Restoring divider by T, one quotient bit per stage
  logic [DIV_STAGES-1:0] dv_vld_r;
  logic                  dv_neg_r [DIV_STAGES];
  logic [25:0]           dv_num_r [DIV_STAGES];
  logic [15:0]           dv_rem_r [DIV_STAGES];
  logic [25:0]           dv_q_r   [DIV_STAGES];

  logic        dn_neg [DIV_STAGES];
  logic [25:0] dn_num [DIV_STAGES];
  logic [15:0] dn_rem [DIV_STAGES];
  logic [25:0] dn_q   [DIV_STAGES];
  logic [16:0] dremx  [DIV_STAGES];
  logic [25:0] dnum_n [DIV_STAGES];
  logic [15:0] drem_n [DIV_STAGES];
  logic [25:0] dq_n   [DIV_STAGES];

  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (k == 0) begin
        dn_neg[k] = b5_neg_r;
        dn_num[k] = b5_num_r;
        dn_rem[k] = '0;
        dn_q[k]   = '0;
      end else begin
        dn_neg[k] = dv_neg_r[k-1];
        dn_num[k] = dv_num_r[k-1];
        dn_rem[k] = dv_rem_r[k-1];
        dn_q[k]   = dv_q_r[k-1];
      end
      dremx[k]  = {dn_rem[k], dn_num[k][25]};
      dnum_n[k] = {dn_num[k][24:0], 1'b0};
      if (dremx[k] >= {1'b0, cfg.t}) begin
        drem_n[k] = 16'(dremx[k] - {1'b0, cfg.t});
        dq_n[k]   = {dn_q[k][24:0], 1'b1};
      end else begin
        drem_n[k] = dremx[k][15:0];
        dq_n[k]   = {dn_q[k][24:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv_vld_r <= '0;
    else        dv_vld_r <= {dv_vld_r[DIV_STAGES-2:0], b5_vld_r};
    for (int k = 0; k < DIV_STAGES; k++) begin
      dv_neg_r[k] <= dn_neg[k];
      dv_num_r[k] <= dnum_n[k];
      dv_rem_r[k] <= drem_n[k];
      dv_q_r[k]   <= dq_n[k];
    end
  end

  // Sign, saturation and output word
  logic        out_vld_r;
  logic [20:0] acc_r, acc_nxt;
  logic [25:0] qf;
  logic        qneg;
  logic [25:0] qneg_val;

  always_comb begin
    qf       = dv_q_r[DIV_STAGES-1];
    qneg     = dv_neg_r[DIV_STAGES-1];
    qneg_val = 26'd0 - qf;
    if (!qneg) begin
      acc_nxt = (qf > ACC_POS_LIM) ? ACC_MAX : qf[20:0];
    end else begin
      acc_nxt = (qf > ACC_NEG_LIM) ? ACC_MIN : qneg_val[20:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else        out_vld_r <= dv_vld_r[DIV_STAGES-1];
    acc_r <= acc_nxt;
  end

  assign out_vld = out_vld_r;
  assign acc     = acc_r;

endmodule

FILE: design/krauss_car_following_accel.sv
// Top level of the Krauss car-following acceleration block: config registers and wiring.
//
// Usage:
//   Input: a query word is taken at a rising edge with start high and busy low.
//   kind selects leader ahead, stop line, or free road (kind 3 acts as free road).
//   Output: out_valid is high for exactly one cycle with out_acceleration, the
//   saturated signed acceleration in 1/256 m/s^2; the receiver cannot hold it off.
//   Throughput: one query per cycle. The front end (3 stages) feeds an 8-word
//   queue that the back end drains every cycle; busy rises only if the queue
//   holds 4 or more words, which steady one-per-cycle flow never reaches.
//   The back end is a 31-stage square-root pipeline, 5 blend stages, a
//   26-stage divider by the step time and an output register.
//   Configuration: cfg_we writes register cfg_index with cfg_wdata; write only
//   while no query is in flight. Unknown indexes are ignored.
//   Reset: synchronous active-low rst_n loads default parameters and empties
//   the pipeline and queue; the block takes queries on the next cycle.
module krauss_car_following_accel import kcf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_kind,
  input  logic [31:0]        in_follower_front_position,
  input  logic [15:0]        in_follower_speed,
  input  logic [31:0]        in_leader_rear_position,
  input  logic [15:0]        in_leader_speed,
  input  logic [15:0]        in_random_fraction,
  output logic               out_valid,
  output logic signed [20:0] out_acceleration,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  // Configuration registers
  logic [15:0] desired_r, limit_r, min_gap_r, eps_r, step_r;
  logic [11:0] accel_r, decel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      desired_r <= RST_DESIRED;
      limit_r   <= RST_LIMIT;
      accel_r   <= RST_ACCEL;
      decel_r   <= RST_DECEL;
      min_gap_r <= RST_MIN_GAP;
      eps_r     <= RST_EPS;
      step_r    <= RST_STEP;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DESIRED: desired_r <= cfg_wdata;
        CFG_LIMIT:   limit_r   <= cfg_wdata;
        CFG_ACCEL:   accel_r   <= cfg_wdata[11:0];
        CFG_DECEL:   decel_r   <= cfg_wdata[11:0];
        CFG_MIN_GAP: min_gap_r <= cfg_wdata;
        CFG_EPS:     eps_r     <= cfg_wdata;
        CFG_STEP:    step_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Live config; zero step time acts as one
  cfg_t cfg;
  always_comb begin
    cfg.desired = desired_r;
    cfg.limit   = limit_r;
    cfg.accel   = accel_r;
    cfg.decel   = decel_r;
    cfg.min_gap = min_gap_r;
    cfg.eps     = eps_r;
    cfg.t       = (step_r == 16'd0) ? 16'd1 : step_r;
  end

  logic   accept, push, q_vld, q_busy, sq_vld, acc_vld;
  qitem_t f_item, q_item, sq_item;
  logic [30:0] sq_root;
  logic [20:0] acc;

  assign accept = start && !q_busy;
  assign busy   = q_busy;

  kcf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .accept     (accept),
    .kind       (in_kind),
    .front_pos  (in_follower_front_position),
    .speed      (in_follower_speed),
    .lead_pos   (in_leader_rear_position),
    .lead_speed (in_leader_speed),
    .rnd        (in_random_fraction),
    .push       (push),
    .item       (f_item)
  );

  kcf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_item  (f_item),
    .rd_valid (q_vld),
    .rd_item  (q_item),
    .busy     (q_busy)
  );

  kcf_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (q_vld),
    .in_item  (q_item),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_item (sq_item)
  );

  kcf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_vld  (sq_vld),
    .root    (sq_root),
    .in_item (sq_item),
    .out_vld (acc_vld),
    .acc     (acc)
  );

  assign out_valid        = acc_vld;
  assign out_acceleration = $signed(acc);

endmodule
